>>> design/ckrr_pkg.sv
package ckrr_pkg;

   localparam int unsigned COORD_W = 13;
   localparam int unsigned COUNT_W = 12;
   localparam int unsigned PIXEL_W = 24;
   localparam int unsigned CSR_IDX_W = 3;

   localparam logic [COORD_W-1:0] MAX_DIM = 13'd4096;
   localparam logic [COUNT_W-1:0] BATCH_LIMIT_RESET = 12'd2000;
   localparam logic [PIXEL_W-1:0] KEY_COLOR_RESET = 24'hFFFFFF;
   localparam logic [COORD_W-1:0] FRAME_WIDTH_RESET = 13'd640;
   localparam logic [COORD_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KEY_COLOR   = 3'd0,
      CSR_KEY_IS_TRANS = 3'd1,
      CSR_FRAME_WIDTH = 3'd2,
      CSR_FRAME_HEIGHT = 3'd3,
      CSR_BATCH_LIMIT = 3'd4
   } csr_index_type;

   typedef enum logic {
      KIND_RECT  = 1'b0,
      KIND_BATCH = 1'b1
   } record_kind_type;

   typedef struct packed {
      logic               frame_done;
      logic [COUNT_W-1:0] rect_total;
      logic [COORD_W-1:0] bottom_y;
      logic [COORD_W-1:0] top_y;
      logic [COORD_W-1:0] right_x;
      logic [COORD_W-1:0] left_x;
      record_kind_type    record_kind;
   } record_type;

   function automatic logic [COORD_W-1:0] clamp_dim(input logic [COORD_W-1:0] v);
      logic [COORD_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = 13'd1;
      end else if (v > MAX_DIM) begin
         r = MAX_DIM;
      end
      return r;
   endfunction

endpackage

>>> design/color_key_run_rectangles.sv
// color key run extractor
// req_ channel: one pixel per beat in raster order, top row first; the pixel's
// 24-bit value is compared with the key color and runs of kept pixels are found.
// rsp_ channel: rectangle records (one row high) and batch close records with
// the bounding box and rectangle count; tlast marks the final batch record of
// a frame. each pixel gives zero to three records.
// csr_ channel: register writes, always ready; write only while the block is idle.
// a pixel's records are written into the output queue at the edge that accepts it.
// throughput: one pixel per cycle while each pixel gives at most one record and
// the receiver takes one record per cycle. the records wait in a four entry
// output queue; req_tready is high while at least three entries are free, so a
// pixel giving several records holds off the input until they drain.
// a receiver stall lets records gather in the queue until fewer than three entries
// are free, which deasserts req_tready; no record is lost.
// reset (synchronous, active high) empties the queue, restarts at row 0
// column 0 with an empty box, and loads the register reset values.
module color_key_run_rectangles (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [23:0]                      req_tdata,   // pixel_word
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [63:0]                      rsp_tdata,   // left_x, right_x, top_y, bottom_y, rect_total
   output logic                             rsp_tuser,   // record_kind
   output logic                             rsp_tlast,   // frame_done
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [ckrr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ckrr_pkg::PIXEL_W-1:0]     csr_data
);

   localparam int unsigned QDEPTH = 4;
   localparam int unsigned QPTR_W = $clog2(QDEPTH);

   logic [ckrr_pkg::PIXEL_W-1:0] key_color_ff;
   logic                         key_trans_ff;
   logic [ckrr_pkg::COORD_W-1:0] frame_width_ff;
   logic [ckrr_pkg::COORD_W-1:0] frame_height_ff;
   logic [ckrr_pkg::COUNT_W-1:0] batch_limit_ff;

   logic [ckrr_pkg::COORD_W-1:0] column_pos_ff, column_pos_in;
   logic [ckrr_pkg::COORD_W-1:0] row_pos_ff, row_pos_in;
   logic                         run_active_ff, run_active_in;
   logic [ckrr_pkg::COORD_W-1:0] run_begin_ff, run_begin_in;
   logic [ckrr_pkg::COUNT_W-1:0] batch_count_ff, batch_count_in;
   logic [ckrr_pkg::COORD_W-1:0] box_left_ff, box_left_in;
   logic [ckrr_pkg::COORD_W-1:0] box_top_ff, box_top_in;
   logic [ckrr_pkg::COORD_W-1:0] box_right_ff, box_right_in;
   logic [ckrr_pkg::COORD_W-1:0] box_bottom_ff, box_bottom_in;

   ckrr_pkg::record_type         queue_ff [QDEPTH];
   logic [QPTR_W-1:0]            wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_W:0]              count_ff, count_in;

   logic                         in_beat, out_beat;
   logic [ckrr_pkg::COORD_W-1:0] w_eff, h_eff, col_inc, row_inc;
   logic [ckrr_pkg::COUNT_W-1:0] lim_eff, count_inc;
   logic                         kept, row_end, frame_end, rect_valid, batch_close;
   logic [ckrr_pkg::COORD_W-1:0] rect_left, rect_right;
   logic [ckrr_pkg::COORD_W-1:0] upd_left, upd_top, upd_right, upd_bottom;
   ckrr_pkg::record_type         rect_rec, batch_rec, final_rec;
   ckrr_pkg::record_type         slot_rec [3];
   logic [1:0]                   push_n;

   assign in_beat    = req_tvalid & req_tready;
   assign out_beat   = rsp_tvalid & rsp_tready;
   assign req_tready = (count_ff <= (QPTR_W+1)'(QDEPTH - 3));
   assign csr_ready  = 1'b1;

   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tdata  = {queue_ff[rd_ptr_ff].rect_total, queue_ff[rd_ptr_ff].bottom_y,
                        queue_ff[rd_ptr_ff].top_y, queue_ff[rd_ptr_ff].right_x,
                        queue_ff[rd_ptr_ff].left_x};
   assign rsp_tuser  = queue_ff[rd_ptr_ff].record_kind;
   assign rsp_tlast  = queue_ff[rd_ptr_ff].frame_done;

   always_comb begin
      w_eff     = ckrr_pkg::clamp_dim(frame_width_ff);
      h_eff     = ckrr_pkg::clamp_dim(frame_height_ff);
      lim_eff   = (batch_limit_ff == '0) ? 12'd1 : batch_limit_ff;
      col_inc   = column_pos_ff + 13'd1;
      row_inc   = row_pos_ff + 13'd1;
      kept      = key_trans_ff ? (req_tdata != key_color_ff) : (req_tdata == key_color_ff);
      row_end   = (col_inc >= w_eff);
      frame_end = row_end && (row_inc >= h_eff);

      rect_valid = (kept && row_end) || (!kept && run_active_ff);
      rect_left  = (kept && !run_active_ff) ? column_pos_ff : run_begin_ff;
      rect_right = kept ? col_inc : column_pos_ff;

      upd_left   = (rect_left < box_left_ff) ? rect_left : box_left_ff;
      upd_top    = (row_pos_ff < box_top_ff) ? row_pos_ff : box_top_ff;
      upd_right  = (rect_right > box_right_ff) ? rect_right : box_right_ff;
      upd_bottom = (row_inc > box_bottom_ff) ? row_inc : box_bottom_ff;
      count_inc  = batch_count_ff + 12'd1;
      batch_close = rect_valid && (count_inc >= lim_eff);

      rect_rec = '{frame_done: 1'b0, rect_total: '0, bottom_y: row_inc, top_y: row_pos_ff,
                   right_x: rect_right, left_x: rect_left,
                   record_kind: ckrr_pkg::KIND_RECT};
      batch_rec = '{frame_done: 1'b0, rect_total: count_inc, bottom_y: upd_bottom,
                    top_y: upd_top, right_x: upd_right, left_x: upd_left,
                    record_kind: ckrr_pkg::KIND_BATCH};

      // box state after the rectangle and a possible batch close
      if (batch_close) begin
         batch_count_in = '0;
         box_left_in    = ckrr_pkg::MAX_DIM;
         box_top_in     = ckrr_pkg::MAX_DIM;
         box_right_in   = '0;
         box_bottom_in  = '0;
      end else if (rect_valid) begin
         batch_count_in = count_inc;
         box_left_in    = upd_left;
         box_top_in     = upd_top;
         box_right_in   = upd_right;
         box_bottom_in  = upd_bottom;
      end else begin
         batch_count_in = batch_count_ff;
         box_left_in    = box_left_ff;
         box_top_in     = box_top_ff;
         box_right_in   = box_right_ff;
         box_bottom_in  = box_bottom_ff;
      end

      final_rec = '{frame_done: 1'b1, rect_total: batch_count_in, bottom_y: box_bottom_in,
                    top_y: box_top_in, right_x: box_right_in, left_x: box_left_in,
                    record_kind: ckrr_pkg::KIND_BATCH};

      if (frame_end) begin
         batch_count_in = '0;
         box_left_in    = ckrr_pkg::MAX_DIM;
         box_top_in     = ckrr_pkg::MAX_DIM;
         box_right_in   = '0;
         box_bottom_in  = '0;
      end

      if (rect_valid) begin
         slot_rec[0] = rect_rec;
         slot_rec[1] = batch_close ? batch_rec : final_rec;
      end else begin
         slot_rec[0] = final_rec;
         slot_rec[1] = final_rec;
      end
      slot_rec[2] = final_rec;
      push_n = 2'({1'b0, rect_valid}) + 2'({1'b0, batch_close}) + 2'({1'b0, frame_end});

      run_active_in = row_end ? 1'b0 : kept;
      run_begin_in  = (kept && !run_active_ff) ? column_pos_ff : run_begin_ff;
      column_pos_in = row_end ? '0 : col_inc;
      if (frame_end) begin
         row_pos_in = '0;
      end else if (row_end) begin
         row_pos_in = row_inc;
      end else begin
         row_pos_in = row_pos_ff;
      end

      count_in = count_ff + (in_beat ? (QPTR_W+1)'(push_n) : '0)
                 - (out_beat ? (QPTR_W+1)'(1) : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_color_ff    <= ckrr_pkg::KEY_COLOR_RESET;
         key_trans_ff    <= 1'b1;
         frame_width_ff  <= ckrr_pkg::FRAME_WIDTH_RESET;
         frame_height_ff <= ckrr_pkg::FRAME_HEIGHT_RESET;
         batch_limit_ff  <= ckrr_pkg::BATCH_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            ckrr_pkg::CSR_KEY_COLOR:    key_color_ff    <= csr_data;
            ckrr_pkg::CSR_KEY_IS_TRANS: key_trans_ff    <= csr_data[0];
            ckrr_pkg::CSR_FRAME_WIDTH:  frame_width_ff  <= csr_data[ckrr_pkg::COORD_W-1:0];
            ckrr_pkg::CSR_FRAME_HEIGHT: frame_height_ff <= csr_data[ckrr_pkg::COORD_W-1:0];
            ckrr_pkg::CSR_BATCH_LIMIT:  batch_limit_ff  <= csr_data[ckrr_pkg::COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_pos_ff  <= '0;
         row_pos_ff     <= '0;
         run_active_ff  <= 1'b0;
         run_begin_ff   <= '0;
         batch_count_ff <= '0;
         box_left_ff    <= ckrr_pkg::MAX_DIM;
         box_top_ff     <= ckrr_pkg::MAX_DIM;
         box_right_ff   <= '0;
         box_bottom_ff  <= '0;
      end else if (in_beat) begin
         column_pos_ff  <= column_pos_in;
         row_pos_ff     <= row_pos_in;
         run_active_ff  <= run_active_in;
         run_begin_ff   <= run_begin_in;
         batch_count_ff <= batch_count_in;
         box_left_ff    <= box_left_in;
         box_top_ff     <= box_top_in;
         box_right_ff   <= box_right_in;
         box_bottom_ff  <= box_bottom_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (in_beat) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(push_n);
         end
         if (out_beat) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_beat) begin
         for (int i = 0; i < 3; i++) begin
            if (2'(i) < push_n) begin
               queue_ff[wr_ptr_ff + QPTR_W'(i)] <= slot_rec[i];
            end
         end
      end
   end

endmodule

>>> tb/ckrr_record_checker.sv
`timescale 1ns / 100ps

module ckrr_record_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [ckrr_pkg::PIXEL_W-1:0]   req_tdata,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [63:0]                    rsp_tdata,
   input  logic                           rsp_tuser,
   input  logic                           rsp_tlast,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  ckrr_pkg::csr_index_type        csr_index,
   input  logic [ckrr_pkg::PIXEL_W-1:0]   csr_data,
   output int                             mismatch_count,
   output int                             records_outstanding,
   output int                             pixels_seen,
   output int                             rects_seen,
   output int                             batches_seen,
   output int                             frames_seen
);

   localparam int RIGHT_LSB  = ckrr_pkg::COORD_W;
   localparam int TOP_LSB    = 2 * ckrr_pkg::COORD_W;
   localparam int BOTTOM_LSB = 3 * ckrr_pkg::COORD_W;
   localparam int TOTAL_LSB  = 4 * ckrr_pkg::COORD_W;

   // register copies
   logic [ckrr_pkg::PIXEL_W-1:0] key_q;
   logic                         keep_nonkey_q;
   logic [ckrr_pkg::COORD_W-1:0] width_q;
   logic [ckrr_pkg::COORD_W-1:0] height_q;
   logic [ckrr_pkg::COUNT_W-1:0] limit_q;

   // scan position, open run and gathered box
   logic [ckrr_pkg::COORD_W-1:0] col_q;
   logic [ckrr_pkg::COORD_W-1:0] row_q;
   logic                         run_on_q;
   logic [ckrr_pkg::COORD_W-1:0] run_left_q;
   logic [ckrr_pkg::COUNT_W-1:0] rect_cnt_q;
   logic [ckrr_pkg::COORD_W-1:0] box_left_q;
   logic [ckrr_pkg::COORD_W-1:0] box_top_q;
   logic [ckrr_pkg::COORD_W-1:0] box_right_q;
   logic [ckrr_pkg::COORD_W-1:0] box_bottom_q;

   ckrr_pkg::record_type predicted_records[$];
   int                   records_checked;

   task automatic report_error(input string msg);
      mismatch_count++;
      // keep the log short when the block is badly broken
      if (mismatch_count <= 40) begin
         $display("ERROR at %0t ns: %s", $time, msg);
      end
   endtask

   function automatic logic [ckrr_pkg::COORD_W-1:0] usable_dim(
      input logic [ckrr_pkg::COORD_W-1:0] v);
      if (v == '0) begin
         return 13'd1;
      end
      if (v > ckrr_pkg::MAX_DIM) begin
         return ckrr_pkg::MAX_DIM;
      end
      return v;
   endfunction

   task automatic clear_box();
      rect_cnt_q = '0;
      box_left_q = ckrr_pkg::MAX_DIM;
      box_top_q = ckrr_pkg::MAX_DIM;
      box_right_q = '0;
      box_bottom_q = '0;
   endtask

   task automatic push_batch(input logic done);
      ckrr_pkg::record_type rec;
      rec.record_kind = ckrr_pkg::KIND_BATCH;
      rec.left_x = box_left_q;
      rec.right_x = box_right_q;
      rec.top_y = box_top_q;
      rec.bottom_y = box_bottom_q;
      rec.rect_total = rect_cnt_q;
      rec.frame_done = done;
      predicted_records.push_back(rec);
   endtask

   task automatic add_rect(input logic [ckrr_pkg::COORD_W-1:0] l,
                           input logic [ckrr_pkg::COORD_W-1:0] r,
                           input logic [ckrr_pkg::COORD_W-1:0] row);
      ckrr_pkg::record_type         rec;
      logic [ckrr_pkg::COUNT_W-1:0] lim;
      lim = (limit_q == '0) ? 12'd1 : limit_q;
      rec.record_kind = ckrr_pkg::KIND_RECT;
      rec.left_x = l;
      rec.right_x = r;
      rec.top_y = row;
      rec.bottom_y = row + 13'd1;
      rec.rect_total = '0;
      rec.frame_done = 1'b0;
      predicted_records.push_back(rec);
      if (l < box_left_q) box_left_q = l;
      if (row < box_top_q) box_top_q = row;
      if (r > box_right_q) box_right_q = r;
      if (row + 13'd1 > box_bottom_q) box_bottom_q = row + 13'd1;
      rect_cnt_q = rect_cnt_q + 12'd1;
      if (rect_cnt_q >= lim) begin
         push_batch(1'b0);
         clear_box();
      end
   endtask

   task automatic advance_pixel(input logic [ckrr_pkg::PIXEL_W-1:0] pix);
      logic [ckrr_pkg::COORD_W-1:0] w;
      logic [ckrr_pkg::COORD_W-1:0] h;
      logic                         kept;
      logic                         row_end;
      w = usable_dim(width_q);
      h = usable_dim(height_q);
      kept = (pix == key_q) ^ keep_nonkey_q;
      row_end = ({1'b0, col_q} + 14'd1) >= {1'b0, w};
      if (kept) begin
         if (!run_on_q) begin
            run_on_q = 1'b1;
            run_left_q = col_q;
         end
         if (row_end) begin
            add_rect(run_left_q, col_q + 13'd1, row_q);
            run_on_q = 1'b0;
         end
      end else if (run_on_q) begin
         add_rect(run_left_q, col_q, row_q);
         run_on_q = 1'b0;
      end
      if (row_end) begin
         run_on_q = 1'b0;
         col_q = '0;
         if (({1'b0, row_q} + 14'd1) >= {1'b0, h}) begin
            push_batch(1'b1);
            clear_box();
            row_q = '0;
         end else begin
            row_q = row_q + 13'd1;
         end
      end else begin
         col_q = col_q + 13'd1;
      end
      pixels_seen++;
   endtask

   task automatic write_reg(input ckrr_pkg::csr_index_type idx,
                            input logic [ckrr_pkg::PIXEL_W-1:0] value);
      case (idx)
         ckrr_pkg::CSR_KEY_COLOR: begin
            key_q = value;
         end
         ckrr_pkg::CSR_KEY_IS_TRANS: begin
            keep_nonkey_q = value[0];
         end
         ckrr_pkg::CSR_FRAME_WIDTH: begin
            width_q = value[ckrr_pkg::COORD_W-1:0];
         end
         ckrr_pkg::CSR_FRAME_HEIGHT: begin
            height_q = value[ckrr_pkg::COORD_W-1:0];
         end
         ckrr_pkg::CSR_BATCH_LIMIT: begin
            limit_q = value[ckrr_pkg::COUNT_W-1:0];
         end
         default: begin
         end
      endcase
   endtask

   task automatic compare_field(input string name, input int got, input int want);
      if (got != want) begin
         report_error($sformatf("record %0d: %s is %0d, expected %0d",
                                records_checked, name, got, want));
      end
   endtask

   task automatic check_record();
      ckrr_pkg::record_type want;
      if (rsp_tuser == ckrr_pkg::KIND_RECT) begin
         rects_seen++;
      end else if (rsp_tlast) begin
         frames_seen++;
      end else begin
         batches_seen++;
      end
      if (predicted_records.size() == 0) begin
         report_error($sformatf("record with nothing expected: kind %0d data %h last %0d",
                                rsp_tuser, rsp_tdata, rsp_tlast));
      end else begin
         want = predicted_records.pop_front();
         compare_field("record_kind", rsp_tuser, want.record_kind);
         compare_field("left_x", rsp_tdata[RIGHT_LSB-1:0], want.left_x);
         compare_field("right_x", rsp_tdata[TOP_LSB-1:RIGHT_LSB], want.right_x);
         compare_field("top_y", rsp_tdata[BOTTOM_LSB-1:TOP_LSB], want.top_y);
         compare_field("bottom_y", rsp_tdata[TOTAL_LSB-1:BOTTOM_LSB], want.bottom_y);
         compare_field("rect_total", rsp_tdata[63:TOTAL_LSB], want.rect_total);
         compare_field("frame_done", rsp_tlast, want.frame_done);
      end
      records_checked++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         key_q = ckrr_pkg::KEY_COLOR_RESET;
         keep_nonkey_q = 1'b1;
         width_q = ckrr_pkg::FRAME_WIDTH_RESET;
         height_q = ckrr_pkg::FRAME_HEIGHT_RESET;
         limit_q = ckrr_pkg::BATCH_LIMIT_RESET;
         col_q = '0;
         row_q = '0;
         run_on_q = 1'b0;
         run_left_q = '0;
         clear_box();
         predicted_records.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            write_reg(csr_index, csr_data);
         end
         if (rsp_tvalid && rsp_tready) begin
            check_record();
         end
         if (req_tvalid && req_tready) begin
            advance_pixel(req_tdata);
         end
      end
      records_outstanding = predicted_records.size();
   end

endmodule

>>> tb/tb_color_key_run_rectangles.sv
`timescale 1ns / 100ps

module tb_color_key_run_rectangles;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [ckrr_pkg::PIXEL_W-1:0]   req_tdata = '0;      // pixel_word
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [63:0]                    rsp_tdata;   // left_x, right_x, top_y, bottom_y, rect_total
   logic                           rsp_tuser;           // record_kind
   logic                           rsp_tlast;           // frame_done
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   ckrr_pkg::csr_index_type        csr_index = ckrr_pkg::CSR_KEY_COLOR;
   logic [ckrr_pkg::PIXEL_W-1:0]   csr_data = '0;

   int mismatch_count;
   int records_outstanding;
   int pixels_seen;
   int rects_seen;
   int batches_seen;
   int frames_seen;

   int send_idle_pct = 12;
   int recv_idle_pct = 64;
   int rsp_hold_len = 0;
   bit hold_toggle = 1'b0;
   bit hold_seen = 1'b0;
   int settings_used = 0;
   logic [ckrr_pkg::PIXEL_W-1:0] cur_key;

   color_key_run_rectangles dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   ckrr_record_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_tvalid          (req_tvalid),
      .req_tready          (req_tready),
      .req_tdata           (req_tdata),
      .rsp_tvalid          (rsp_tvalid),
      .rsp_tready          (rsp_tready),
      .rsp_tdata           (rsp_tdata),
      .rsp_tuser           (rsp_tuser),
      .rsp_tlast           (rsp_tlast),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .mismatch_count      (mismatch_count),
      .records_outstanding (records_outstanding),
      .pixels_seen         (pixels_seen),
      .rects_seen          (rects_seen),
      .batches_seen        (batches_seen),
      .frames_seen         (frames_seen)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      #3_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // receiver: random stalls, or a long hold-off when requested
   initial begin
      forever begin
         @(negedge clock);
         if (hold_toggle != hold_seen) begin
            hold_seen = hold_toggle;
            rsp_hold_len = 400;
         end
         if (rsp_hold_len > 0) begin
            rsp_tready <= 1'b0;
            rsp_hold_len--;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   task automatic send_pixel(input logic [ckrr_pkg::PIXEL_W-1:0] pix);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= pix;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (records_outstanding != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_reg(input ckrr_pkg::csr_index_type idx,
                            input logic [ckrr_pkg::PIXEL_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_frame(input logic [ckrr_pkg::PIXEL_W-1:0] key, input logic keep_nonkey,
                            input int width, input int height, input int limit);
      write_reg(ckrr_pkg::CSR_KEY_COLOR, key);
      write_reg(ckrr_pkg::CSR_KEY_IS_TRANS, ckrr_pkg::PIXEL_W'(keep_nonkey));
      write_reg(ckrr_pkg::CSR_FRAME_WIDTH, ckrr_pkg::PIXEL_W'(width));
      write_reg(ckrr_pkg::CSR_FRAME_HEIGHT, ckrr_pkg::PIXEL_W'(height));
      write_reg(ckrr_pkg::CSR_BATCH_LIMIT, ckrr_pkg::PIXEL_W'(limit));
      cur_key = key;
      settings_used++;
   endtask

   function automatic int random_dim(input int typical_max);
      int pick;
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
         return 0;
      end
      if (pick == 1) begin
         return $urandom_range(4097, 8191);
      end
      return $urandom_range(1, typical_max);
   endfunction

   task automatic configure_random();
      logic [ckrr_pkg::PIXEL_W-1:0] key;
      int                           limit;
      case ($urandom_range(0, 5))
         0: key = '0;
         1: key = '1;
         default: key = ckrr_pkg::PIXEL_W'($urandom);
      endcase
      case ($urandom_range(0, 9))
         0: limit = 0;
         1: limit = 4095;
         default: limit = $urandom_range(1, 6);
      endcase
      set_frame(key, 1'($urandom_range(0, 1)), random_dim(10), random_dim(5), limit);
   endtask

   // key pixels, near misses of the key, and arbitrary values
   function automatic logic [ckrr_pkg::PIXEL_W-1:0] random_pixel(
      input logic [ckrr_pkg::PIXEL_W-1:0] key);
      case ($urandom_range(0, 3))
         0, 1: return key;
         2: return key ^ (24'h1 << $urandom_range(0, ckrr_pkg::PIXEL_W - 1));
         default: return ckrr_pkg::PIXEL_W'($urandom);
      endcase
   endfunction

   task automatic run_phase(input int s_pct, input int r_pct, input bit with_hold);
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      for (int seg = 0; seg < 3; seg++) begin
         wait_idle();
         configure_random();
         if (with_hold && seg == 1) begin
            hold_toggle = ~hold_toggle;
         end
         repeat (45) send_pixel(random_pixel(cur_key));
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: one short run mid row
      send_pixel(24'hFFFFFF);
      send_pixel(24'h123456);
      send_pixel(24'hFFFFFF);
      wait_idle();

      // zero sizes and limit: position is past the shrunk frame, limit below count
      set_frame(24'h000000, 1'b1, 0, 0, 0);
      send_pixel(24'hFFFFFF);
      send_pixel(24'h000000);
      send_pixel(24'h800001);
      wait_idle();

      // key runs kept, oversize frame, largest limit
      set_frame(24'h5A5A5A, 1'b0, 8191, 8191, 4095);
      send_pixel(24'h5A5A5A);
      send_pixel(24'h5A5A5A);
      send_pixel(24'h000000);
      send_pixel(24'h5A5A5A);
      send_pixel(24'hFFFFFF);
      send_pixel(24'h5A5A5A);
      send_pixel(24'h5A5A5A);
      wait_idle();

      // shrink mid row with an open run; batch closes on the frame's last rectangle
      write_reg(ckrr_pkg::CSR_FRAME_WIDTH, 24'd4);
      write_reg(ckrr_pkg::CSR_FRAME_HEIGHT, 24'd2);
      write_reg(ckrr_pkg::CSR_BATCH_LIMIT, 24'd1);
      settings_used++;
      send_pixel(24'h5A5A5A);
      send_pixel(24'hA5A5A5);
      send_pixel(24'h5A5A5A);
      send_pixel(24'h5A5A5A);
      send_pixel(24'h5A5A5A);

      run_phase(12, 64, 1'b0);
      run_phase(64, 12, 1'b0);
      run_phase(0, 0, 1'b1);

      req_tvalid <= 1'b0;
      @(negedge clock);
      while (records_outstanding != 0) @(negedge clock);
      repeat (20) @(negedge clock);

      $display("covered %0d pixels under %0d register settings, zero and oversize sizes included",
               pixels_seen, settings_used);
      $display("checked %0d run rectangles, %0d batch closes and %0d frame ends",
               rects_seen, batches_seen, frames_seen);
      if (mismatch_count == 0 && records_outstanding == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
